/* design/kbs_pkg.sv */
// shared types and codes for the keyed bucket store
package kbs_pkg;

	typedef enum logic [2:0] {
		REQ_LOOKUP  = 3'd0,
		REQ_STORE   = 3'd1,
		REQ_PROBE   = 3'd2,
		REQ_REFRESH = 3'd3,
		REQ_DELETE  = 3'd4
	} req_t;

	typedef enum logic [1:0] {
		ST_DONE     = 2'd0,
		ST_NOTFOUND = 2'd1,
		ST_NOSLOT   = 2'd2,
		ST_TOOLONG  = 2'd3
	} status_t;

	localparam logic [1:0] CFG_W0 = 2'd0;
	localparam logic [1:0] CFG_W1 = 2'd1;
	localparam logic [1:0] CFG_W2 = 2'd2;
	localparam logic [1:0] CFG_W3 = 2'd3;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_CLEAR,
		BK_READ,
		BK_SCAN,
		BK_WRITE,
		BK_REPLY
	} bk_state_t;

	// first-difference index, 0 = msb, 256 = equal
	function automatic logic [8:0] first_diff(input logic [255:0] x);
		logic [8:0] r;
		r = 9'd256;
		for (int i = 0; i < 256; i++) begin
			if (x[i] == 1'b1) begin
				r = 9'(255 - i);
			end
		end
		return r;
	endfunction

endpackage

/* design/kbs_front.sv */
// front end: key distance, bucket select and request classification
module kbs_front #(
	parameter int NUM_BUCKETS = 32,
	parameter int PREFIX_BITS = 5,
	parameter int MAX_PAYLOAD = 512,
	parameter int BW = 5
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	input  logic [2:0]   in_req,
	input  logic [255:0] in_key,
	input  logic [255:0] own_key,
	input  logic [15:0]  in_len,
	output logic         out_valid,
	output logic [BW-1:0] out_bucket,
	output logic [8:0]   out_diff,
	output logic         out_toolong
);
	logic [8:0]   d_s1;
	logic [255:0] xk_s1;
	logic [2:0]   req_s1;
	logic [15:0]  len_s1;
	logic         v_s1;
	logic [PREFIX_BITS-1:0] pre;
	logic [PREFIX_BITS-1:0] pre_mod;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			out_valid <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			d_s1 <= kbs_pkg::first_diff(in_key ^ own_key);
			xk_s1 <= in_key ^ own_key;
			req_s1 <= in_req;
			len_s1 <= in_len;
		end
	end

	// xor of the prefix bits after the first difference; past bit 255 reads zero
	always_comb begin
		for (int t = 0; t < PREFIX_BITS; t++) begin
			pre[PREFIX_BITS-1-t] = ((32'(d_s1) + 1 + t) < 256) ?
				xk_s1[8'(255 - (32'(d_s1) + 1 + t))] : 1'b0;
		end
	end

	// reduce to the bucket count by compare and subtract
	always_comb begin
		pre_mod = pre;
		for (int s = PREFIX_BITS - 1; s >= 0; s--) begin
			if (32'(pre_mod) >= (NUM_BUCKETS << s))
				pre_mod = pre_mod - PREFIX_BITS'(NUM_BUCKETS << s);
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			out_bucket <= BW'(pre_mod);
			out_diff <= d_s1;
			out_toolong <= (req_s1 == kbs_pkg::REQ_STORE) && (32'(len_s1) > MAX_PAYLOAD);
		end
	end
endmodule

/* design/kbs_back.sv */
// back end: clearing pass after reset, bucket scan, slot choice, write-back and reply
module kbs_back #(
	parameter int WAYS_PER_BUCKET = 8,
	parameter int BW = 5,
	parameter int WW = 3,
	parameter int DEPTH = 256
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         go,
	input  logic [2:0]   req,
	input  logic [255:0] key,
	input  logic [255:0] own_key,
	input  logic [63:0]  now,
	input  logic [31:0]  lifetime,
	input  logic [15:0]  plen,
	input  logic [31:0]  pref,
	input  logic [BW-1:0] bucket,
	input  logic [8:0]   diff,
	input  logic         toolong,
	output logic         ready,
	output logic         done,
	output logic [1:0]   status,
	output logic [7:0]   slot_index,
	output logic [9:0]   stored_length,
	output logic [31:0]  stored_ref,
	output logic [63:0]  expires_at
);
	localparam int AW = $clog2(DEPTH);
	logic [255:0] key_mem [DEPTH];
	logic [63:0]  exp_mem [DEPTH];
	logic [9:0]   len_mem [DEPTH];
	logic [31:0]  ref_mem [DEPTH];

	kbs_pkg::bk_state_t st_q, st_d;
	logic [AW:0]  clr_q;
	logic [WW:0]  way_q;
	logic [AW-1:0] raddr;
	logic [255:0] rkey_q;
	logic [63:0]  rexp_q;
	logic [9:0]   rlen_q;
	logic [31:0]  rref_q;
	logic         hit_q, have_q;
	logic [WW-1:0] slot_q;
	logic [8:0]   best_q;
	logic [8:0]   ed;
	logic         match, empty, lkp;
	logic [AW-1:0] waddr;

	assign lkp = (req == kbs_pkg::REQ_LOOKUP) || (req == kbs_pkg::REQ_REFRESH) ||
		(req == kbs_pkg::REQ_DELETE);
	assign raddr = AW'({bucket, way_q[WW-1:0]});
	assign waddr = AW'({bucket, slot_q});
	assign match = (rkey_q == key);
	assign empty = (now >= rexp_q);
	assign ed = kbs_pkg::first_diff(rkey_q ^ own_key);
	assign ready = (st_q == kbs_pkg::BK_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= kbs_pkg::BK_CLEAR;
		else st_q <= st_d;
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			kbs_pkg::BK_IDLE: begin
				if (go) begin
					if (toolong || req > kbs_pkg::REQ_DELETE) st_d = kbs_pkg::BK_REPLY;
					else st_d = kbs_pkg::BK_READ;
				end
			end
			kbs_pkg::BK_CLEAR: if (clr_q[AW]) st_d = kbs_pkg::BK_IDLE;
			kbs_pkg::BK_READ: st_d = kbs_pkg::BK_SCAN;
			kbs_pkg::BK_SCAN: begin
				if ((match) || (32'(way_q) == WAYS_PER_BUCKET - 1)) st_d = kbs_pkg::BK_WRITE;
				else st_d = kbs_pkg::BK_READ;
			end
			kbs_pkg::BK_WRITE: st_d = kbs_pkg::BK_REPLY;
			kbs_pkg::BK_REPLY: st_d = kbs_pkg::BK_IDLE;
			default: st_d = kbs_pkg::BK_IDLE;
		endcase
	end

	// clearing pass, scan bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			way_q <= '0;
			hit_q <= 1'b0;
			have_q <= 1'b0;
			slot_q <= '0;
			best_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (st_q == kbs_pkg::BK_CLEAR) clr_q <= clr_q + 1'b1;
			if (st_q == kbs_pkg::BK_IDLE) begin
				way_q <= '0;
				hit_q <= 1'b0;
				have_q <= 1'b0;
				best_q <= diff;
			end
			if (st_q == kbs_pkg::BK_SCAN && !hit_q) begin
				way_q <= way_q + 1'b1;
				if (match) begin
					hit_q <= lkp ? !empty : 1'b1;
					have_q <= 1'b1;
					slot_q <= way_q[WW-1:0];
				end else if (!lkp && empty) begin
					have_q <= 1'b1;
					slot_q <= way_q[WW-1:0];
					best_q <= '0;
				end else if (!lkp && ed < best_q) begin
					have_q <= 1'b1;
					slot_q <= way_q[WW-1:0];
					best_q <= ed;
				end
			end
			if (st_q == kbs_pkg::BK_REPLY) done <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == kbs_pkg::BK_CLEAR && !clr_q[AW]) begin
			key_mem[clr_q[AW-1:0]] <= '0;
			exp_mem[clr_q[AW-1:0]] <= '0;
			len_mem[clr_q[AW-1:0]] <= '0;
			ref_mem[clr_q[AW-1:0]] <= '0;
		end else if (st_q == kbs_pkg::BK_WRITE) begin
			if (req == kbs_pkg::REQ_STORE && have_q) begin
				key_mem[waddr] <= key;
				exp_mem[waddr] <= now + 64'(lifetime);
				len_mem[waddr] <= plen[9:0];
				ref_mem[waddr] <= pref;
			end else if (req == kbs_pkg::REQ_REFRESH && hit_q) begin
				exp_mem[waddr] <= now + 64'(lifetime);
			end else if (req == kbs_pkg::REQ_DELETE && hit_q) begin
				exp_mem[waddr] <= '0;
			end
		end
		rkey_q <= key_mem[(st_q == kbs_pkg::BK_WRITE) ? waddr : raddr];
		rexp_q <= exp_mem[(st_q == kbs_pkg::BK_WRITE) ? waddr : raddr];
		rlen_q <= len_mem[(st_q == kbs_pkg::BK_WRITE) ? waddr : raddr];
		rref_q <= ref_mem[(st_q == kbs_pkg::BK_WRITE) ? waddr : raddr];
	end

	logic ok;
	assign ok = lkp ? hit_q : have_q;
	// the entry read during write-back holds old data, so report what was written
	always_ff @(posedge clk) begin
		if (st_q == kbs_pkg::BK_REPLY) begin
			if (toolong) status <= kbs_pkg::ST_TOOLONG;
			else if (req > kbs_pkg::REQ_DELETE) status <= kbs_pkg::ST_NOTFOUND;
			else if (ok) status <= kbs_pkg::ST_DONE;
			else if (lkp) status <= kbs_pkg::ST_NOTFOUND;
			else status <= kbs_pkg::ST_NOSLOT;
			if (ok && !toolong && req <= kbs_pkg::REQ_DELETE) begin
				slot_index <= 8'(32'(bucket) * WAYS_PER_BUCKET + 32'(slot_q));
				stored_length <= (req == kbs_pkg::REQ_STORE) ? plen[9:0] : rlen_q;
				stored_ref <= (req == kbs_pkg::REQ_STORE) ? pref : rref_q;
				if (req == kbs_pkg::REQ_STORE || req == kbs_pkg::REQ_REFRESH)
					expires_at <= now + 64'(lifetime);
				else if (req == kbs_pkg::REQ_DELETE)
					expires_at <= '0;
				else
					expires_at <= rexp_q;
			end else begin
				slot_index <= '0;
				stored_length <= '0;
				stored_ref <= '0;
				expires_at <= '0;
			end
		end
	end

	a_done_after_reply: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == kbs_pkg::BK_REPLY |=> done) else $error("missing done");
	a_scan_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == kbs_pkg::BK_READ |=> st_q == kbs_pkg::BK_SCAN) else $error("bad read");
	a_no_ready_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == kbs_pkg::BK_SCAN |-> !ready) else $error("ready in scan");
endmodule

/* design/keyed_bucket_store_with_expiry.sv */
// top level: keyed bucket store with expiry
// request path: front stages s1 and out, the go queue, then a read and a scan state per way
// until a match or the last way, then write-back and reply; rejected or unknown requests skip the scan
// throughput: one request at a time; busy falls after the strobe
// reset: asynchronous, clears own key; then a clearing pass over every entry, and a
// request taken meanwhile waits for it; the receiver cannot stall the strobe
module keyed_bucket_store_with_expiry #(
	parameter int NUM_BUCKETS = 32,
	parameter int WAYS_PER_BUCKET = 8,
	parameter int PREFIX_BITS = 5,
	parameter int MAX_PAYLOAD = 512
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  req_type,
	input  logic [63:0] key_w0,
	input  logic [63:0] key_w1,
	input  logic [63:0] key_w2,
	input  logic [63:0] key_w3,
	input  logic [63:0] now,
	input  logic [31:0] lifetime,
	input  logic [15:0] payload_length,
	input  logic [31:0] payload_ref,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data,
	output logic        result_valid,
	output logic [1:0]  status,
	output logic [7:0]  slot_index,
	output logic [9:0]  stored_length,
	output logic [31:0] stored_ref,
	output logic [63:0] expires_at
);
	localparam int BW = $clog2(NUM_BUCKETS);
	localparam int WW = (WAYS_PER_BUCKET > 1) ? $clog2(WAYS_PER_BUCKET) : 1;
	localparam int DEPTH = NUM_BUCKETS * (1 << WW);

	logic [255:0] own_q, key_q;
	logic [2:0]  req_q;
	logic [63:0] now_q;
	logic [31:0] life_q, pref_q;
	logic [15:0] len_q;
	logic        busy_q, fv, bk_ready, go_q;
	logic [BW-1:0] bucket, bucket_q;
	logic [8:0]  diff, diff_q;
	logic        tl, tl_q;

	assign cfg_ready = 1'b1;
	assign busy = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_q <= '0;
			busy_q <= 1'b0;
			go_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					kbs_pkg::CFG_W0: own_q[255:192] <= cfg_data;
					kbs_pkg::CFG_W1: own_q[191:128] <= cfg_data;
					kbs_pkg::CFG_W2: own_q[127:64] <= cfg_data;
					kbs_pkg::CFG_W3: own_q[63:0] <= cfg_data;
					default: own_q <= own_q;
				endcase
			end
			if (start && !busy_q) busy_q <= 1'b1;
			else if (result_valid) busy_q <= 1'b0;
			// one-entry queue between front and back
			if (fv) go_q <= 1'b1;
			else if (go_q && bk_ready) go_q <= 1'b0;
			else go_q <= go_q;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			key_q <= {key_w0, key_w1, key_w2, key_w3};
			req_q <= req_type;
			now_q <= now;
			life_q <= lifetime;
			len_q <= payload_length;
			pref_q <= payload_ref;
		end
		if (fv) begin
			bucket_q <= bucket;
			diff_q <= diff;
			tl_q <= tl;
		end
	end

	kbs_front #(.NUM_BUCKETS(NUM_BUCKETS), .PREFIX_BITS(PREFIX_BITS),
		.MAX_PAYLOAD(MAX_PAYLOAD), .BW(BW)) u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(start && !busy_q), .in_req(req_type),
		.in_key({key_w0, key_w1, key_w2, key_w3}), .own_key(own_q),
		.in_len(payload_length), .out_valid(fv), .out_bucket(bucket),
		.out_diff(diff), .out_toolong(tl)
	);

	kbs_back #(.WAYS_PER_BUCKET(WAYS_PER_BUCKET), .BW(BW), .WW(WW), .DEPTH(DEPTH)) u_back (
		.clk(clk), .arst_n(arst_n), .go(go_q && bk_ready), .req(req_q), .key(key_q),
		.own_key(own_q), .now(now_q), .lifetime(life_q), .plen(len_q), .pref(pref_q),
		.bucket(bucket_q), .diff(diff_q), .toolong(tl_q), .ready(bk_ready),
		.done(result_valid), .status(status), .slot_index(slot_index),
		.stored_length(stored_length), .stored_ref(stored_ref), .expires_at(expires_at)
	);
endmodule

/* tb/keyed_bucket_store_with_expiry_tb.sv */
// testbench for the keyed bucket store with expiry
`timescale 1ns / 100ps

module keyed_bucket_store_with_expiry_tb;

	localparam int N_BUCKETS = 32;
	localparam int N_WAYS = 8;
	localparam int N_PREFIX = 5;
	localparam int PAYLOAD_LIMIT = 512;
	localparam int N_ENTRIES = N_BUCKETS * N_WAYS;
	localparam longint CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [1:0]  st;
		logic [7:0]  slot;
		logic [9:0]  len;
		logic [31:0] handle;
		logic [63:0] expiry;
	} reply_t;

	// expected replies in request order
	class reply_board;
		reply_t pending[$];
		int mismatches;
		int checked;

		function void note(reply_t r);
			pending.push_back(r);
		endfunction

		function void check(reply_t got);
			reply_t want;
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected reply st=%0d slot=%0d", got.st, got.slot);
				return;
			end
			want = pending.pop_front();
			checked++;
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10)
					$display("reply %0d: exp st=%0d slot=%0d len=%0d ref=%h exp=%h, ",
						checked, want.st, want.slot, want.len, want.handle, want.expiry,
						"got st=%0d slot=%0d len=%0d ref=%h exp=%h",
						got.st, got.slot, got.len, got.handle, got.expiry);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [2:0] req_type = '0;
	logic [63:0] key_w0 = '0, key_w1 = '0, key_w2 = '0, key_w3 = '0;
	logic [63:0] now = '0;
	logic [31:0] lifetime = '0;
	logic [15:0] payload_length = '0;
	logic [31:0] payload_ref = '0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [63:0] cfg_data = '0;
	logic result_valid;
	logic [1:0] status;
	logic [7:0] slot_index;
	logic [9:0] stored_length;
	logic [31:0] stored_ref;
	logic [63:0] expires_at;

	keyed_bucket_store_with_expiry dut (.*);

	always #6 clk = ~clk;

	// predictor state
	logic [255:0] own_key;
	logic [255:0] tbl_key[N_ENTRIES];
	logic [63:0] tbl_expiry[N_ENTRIES];
	logic [9:0] tbl_len[N_ENTRIES];
	logic [31:0] tbl_handle[N_ENTRIES];

	reply_board board = new();
	longint cycles = 0;
	int sent = 0;
	int idle_pct = 26;
	int op_count[8];
	logic [63:0] clock_now = 64'd1000;
	logic [255:0] key_pool[16];

	function automatic int diff_index(logic [255:0] a, logic [255:0] b);
		logic [255:0] x;
		x = a ^ b;
		for (int p = 0; p < 256; p++)
			if (x[255 - p]) return p;
		return 256;
	endfunction

	function automatic int prefix_at(logic [255:0] k, int pos);
		int v;
		v = 0;
		for (int t = 0; t < N_PREFIX; t++)
			v = (v << 1) | ((pos + t < 256) ? k[255 - (pos + t)] : 0);
		return v;
	endfunction

	function automatic int find_live(int base, logic [255:0] k, logic [63:0] t);
		for (int i = 0; i < N_WAYS; i++)
			if (tbl_key[base + i] == k) return (t >= tbl_expiry[base + i]) ? -1 : base + i;
		return -1;
	endfunction

	function automatic int choose_slot(int base, logic [255:0] k, logic [63:0] t);
		int slot, best, d;
		slot = -1;
		best = diff_index(own_key, k);
		for (int i = 0; i < N_WAYS; i++) begin
			if (tbl_key[base + i] == k) return base + i;
			if (t >= tbl_expiry[base + i]) begin
				slot = base + i;
				best = 0;
			end else begin
				d = diff_index(own_key, tbl_key[base + i]);
				if (d < best) begin
					slot = base + i;
					best = d;
				end
			end
		end
		return slot;
	endfunction

	function automatic reply_t predict_request(logic [2:0] op, logic [255:0] k, logic [63:0] t,
			logic [31:0] life, logic [15:0] plen, logic [31:0] pref);
		reply_t r;
		int d, base, s;
		logic [1:0] st;
		d = diff_index(own_key, k);
		base = ((prefix_at(own_key, d + 1) ^ prefix_at(k, d + 1)) % N_BUCKETS) * N_WAYS;
		s = -1;
		st = kbs_pkg::ST_NOTFOUND;
		case (op)
			kbs_pkg::REQ_LOOKUP: begin
				s = find_live(base, k, t);
				st = (s < 0) ? kbs_pkg::ST_NOTFOUND : kbs_pkg::ST_DONE;
			end
			kbs_pkg::REQ_STORE: begin
				if (plen > PAYLOAD_LIMIT) st = kbs_pkg::ST_TOOLONG;
				else begin
					s = choose_slot(base, k, t);
					if (s < 0) st = kbs_pkg::ST_NOSLOT;
					else begin
						tbl_key[s] = k;
						tbl_len[s] = plen[9:0];
						tbl_handle[s] = pref;
						tbl_expiry[s] = t + 64'(life);
						st = kbs_pkg::ST_DONE;
					end
				end
			end
			kbs_pkg::REQ_PROBE: begin
				s = choose_slot(base, k, t);
				st = (s < 0) ? kbs_pkg::ST_NOSLOT : kbs_pkg::ST_DONE;
			end
			kbs_pkg::REQ_REFRESH: begin
				s = find_live(base, k, t);
				if (s >= 0) begin
					tbl_expiry[s] = t + 64'(life);
					st = kbs_pkg::ST_DONE;
				end
			end
			kbs_pkg::REQ_DELETE: begin
				s = find_live(base, k, t);
				if (s >= 0) begin
					tbl_expiry[s] = '0;
					st = kbs_pkg::ST_DONE;
				end
			end
			default: st = kbs_pkg::ST_NOTFOUND;
		endcase
		r = '0;
		r.st = st;
		if (st == kbs_pkg::ST_DONE && s >= 0) begin
			r.slot = s[7:0];
			r.len = tbl_len[s];
			r.handle = tbl_handle[s];
			r.expiry = tbl_expiry[s];
		end
		return r;
	endfunction

	always @(posedge clk) begin
		cycles++;
		if (result_valid)
			board.check('{status, slot_index, stored_length, stored_ref, expires_at});
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("keyed_bucket_store_with_expiry_tb NOT OK");
			$finish;
		end
	end

	task automatic idle_gap();
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic send_request(logic [2:0] op, logic [255:0] k, logic [63:0] t,
			logic [31:0] life, logic [15:0] plen, logic [31:0] pref);
		idle_gap();
		start <= 1'b1;
		req_type <= op;
		{key_w0, key_w1, key_w2, key_w3} <= k;
		now <= t;
		lifetime <= life;
		payload_length <= plen;
		payload_ref <= pref;
		@(posedge clk);
		while (busy) @(posedge clk);
		board.note(predict_request(op, k, t, life, plen, pref));
		op_count[op]++;
		sent++;
	endtask

	task automatic drain();
		start <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (30) @(posedge clk);
	endtask

	task automatic write_own_key(logic [255:0] k);
		for (int w = 0; w < 4; w++) begin
			while ($urandom_range(99) < idle_pct) begin
				cfg_valid <= 1'b0;
				@(posedge clk);
			end
			cfg_valid <= 1'b1;
			cfg_index <= 2'(w);
			cfg_data <= k[255 - 64 * w -: 64];
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
		end
		cfg_valid <= 1'b0;
		own_key = k;
	endtask

	function automatic logic [255:0] rand_key();
		return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
	endfunction

	// key close to the own key: differ at a chosen bit, random tail
	function automatic logic [255:0] near_key(int pos);
		logic [255:0] k;
		k = rand_key();
		for (int p = 0; p < pos; p++) k[255 - p] = own_key[255 - p];
		k[255 - pos] = ~own_key[255 - pos];
		return k;
	endfunction

	task automatic random_phase(int count);
		logic [255:0] k;
		logic [2:0] op;
		logic [31:0] life;
		logic [15:0] plen;
		int pick;
		for (int j = 0; j < 16; j++) key_pool[j] = near_key($urandom_range(0, 12));
		for (int n = 0; n < count; n++) begin
			idle_pct = (n >= count / 3 && n < count / 2) ? 0 : 26;
			pick = $urandom_range(99);
			if (pick < 70) k = key_pool[$urandom_range(15)];
			else if (pick < 85) k = near_key($urandom_range(0, 255));
			else if (pick < 95) k = rand_key();
			else k = own_key;
			pick = $urandom_range(99);
			if (pick < 35) op = kbs_pkg::REQ_STORE;
			else if (pick < 60) op = kbs_pkg::REQ_LOOKUP;
			else if (pick < 72) op = kbs_pkg::REQ_PROBE;
			else if (pick < 84) op = kbs_pkg::REQ_REFRESH;
			else if (pick < 95) op = kbs_pkg::REQ_DELETE;
			else op = 3'($urandom_range(5, 7));
			clock_now += 64'($urandom_range(0, 40));
			life = ($urandom_range(9) == 0) ? $urandom : $urandom_range(1, 200);
			plen = ($urandom_range(9) == 0) ? 16'($urandom) : 16'($urandom_range(0, PAYLOAD_LIMIT));
			send_request(op, k, clock_now, life, plen, $urandom);
		end
	endtask

	initial begin
		logic [255:0] k;
		own_key = '0;
		for (int i = 0; i < N_ENTRIES; i++) begin
			tbl_key[i] = '0;
			tbl_expiry[i] = '0;
			tbl_len[i] = '0;
			tbl_handle[i] = '0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes and special cases, own key still zero
		k = {64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
			64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF};
		send_request(kbs_pkg::REQ_LOOKUP, k, '1, '1, '1, '1);
		send_request(kbs_pkg::REQ_STORE, k, 64'd10, 32'd100, 16'(PAYLOAD_LIMIT), 32'hFFFF_FFFF);
		send_request(kbs_pkg::REQ_STORE, k, 64'd10, 32'd100, 16'(PAYLOAD_LIMIT + 1), 32'h1);
		send_request(kbs_pkg::REQ_STORE, k, 64'd10, 32'd100, 16'hFFFF, 32'h1);
		send_request(kbs_pkg::REQ_LOOKUP, k, 64'd20, '0, '0, '0);
		send_request(kbs_pkg::REQ_PROBE, k, 64'd20, '0, '0, '0);
		send_request(kbs_pkg::REQ_REFRESH, k, 64'd20, 32'hFFFF_FFFF, '0, '0);
		send_request(kbs_pkg::REQ_DELETE, k, 64'd21, '0, '0, '0);
		send_request(kbs_pkg::REQ_LOOKUP, k, 64'd21, '0, '0, '0);
		// own key itself, expiry wrapping past 2^64
		send_request(kbs_pkg::REQ_STORE, '0, 64'hFFFF_FFFF_FFFF_FFF0, 32'h100, 16'd0, 32'h0);
		send_request(kbs_pkg::REQ_STORE, '0, 64'd5, 32'd0, 16'd3, 32'h5);
		send_request(kbs_pkg::REQ_LOOKUP, '0, 64'd5, '0, '0, '0);
		for (int c = 5; c < 8; c++) send_request(3'(c), k, 64'd30, '1, '1, '1);
		// fill one bucket past its ways to reach no-slot
		for (int j = 0; j < 10; j++)
			send_request(kbs_pkg::REQ_STORE, {5'b10000, 3'd0, 248'(j)}, 64'd40, 32'd1000,
				16'(j), 32'(j));
		send_request(kbs_pkg::REQ_PROBE, {8'h87, 248'h55}, 64'd40, '0, '0, '0);
		drain();

		write_own_key({64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
			64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF});
		clock_now = 64'd2000;
		random_phase(200);
		drain();
		// hold off until everything is back, then continue
		write_own_key(rand_key());
		random_phase(300);
		drain();
		write_own_key('0);
		random_phase(230);
		drain();

		$display("%0d requests: lookup %0d store %0d probe %0d refresh %0d delete %0d, ",
			sent, op_count[0], op_count[1], op_count[2], op_count[3], op_count[4],
			"%0d replies checked", board.checked);
		$display("own key set to zero, all ones and random; bucket overflow and expiry wrap exercised");
		if (board.mismatches == 0 && board.pending.size() == 0)
			$display("keyed_bucket_store_with_expiry_tb OK");
		else
			$display("keyed_bucket_store_with_expiry_tb NOT OK");
		$finish;
	end

endmodule
